FILE: sv/svms_pkg.sv
// Shared constants for the sampled voxel mean and standard deviation block.
package svms_pkg;

    // Volume limits; the store holds VOL_X * VOL_Y * VOL_Z bytes.
    localparam int VOL_X      = 64;
    localparam int VOL_Y      = 64;
    localparam int VOL_Z      = 32;
    localparam int MAX_POINTS = 65536;

    localparam int STORE_DEPTH = 131072;
    localparam int STORE_AW    = 17;
    localparam int VOXEL_W     = 8;

    // Register and field widths.
    localparam int SIZE_XY_W = 7;
    localparam int SIZE_Z_W  = 6;
    localparam int COORD_W   = 6;
    localparam int ZY_W      = 11;
    localparam int COUNT_W   = 17;
    localparam int SUM_W     = 24;
    localparam int SUMSQ_W   = 32;
    localparam int RESULT_W  = 16;

    // Largest count that the accumulator can hold; the count stops at POINT_LIMIT below.
    localparam int COUNT_MAX = 131071;
    localparam int POINT_LIMIT = (MAX_POINTS < COUNT_MAX) ? MAX_POINTS : COUNT_MAX;

    // Function codes of an input item.
    localparam logic [1:0] FUNC_LOAD   = 2'd0;
    localparam logic [1:0] FUNC_SAMPLE = 2'd1;
    localparam logic [1:0] FUNC_FINISH = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_SIZE_X = 2'd0;
    localparam logic [1:0] CFG_SIZE_Y = 2'd1;
    localparam logic [1:0] CFG_SIZE_Z = 2'd2;

endpackage

FILE: sv/sampled_voxel_mean_std_top.sv
// Top level of the sampled voxel mean and standard deviation block.
//
// The block keeps a 128 KiB voxel store in a synchronous RAM and takes one item at a time.
// A load item writes one byte into the store. A sample item rounds its three Q.4 coordinates,
// checks them against the configured size and, when the point is inside, computes the store
// address with one multiply when it is taken and one in ST_ADDR, reads the voxel and adds it
// to the count, sum and sum of squares; a point that lies outside or is dropped at the point
// limit leaves the block idle. A finish item reports mean and population standard deviation
// in Q8.8 and clears the accumulators; after the cycle that takes it, ST_MULA and ST_MULB
// multiply, ST_DIFF forms the difference, in ST_ROOT a digit-by-digit square root unit and a
// restoring divider (for the mean) step together, in ST_DIVS the divider scales the root, and
// ST_OUT loads the output register; when no sample was counted the finish goes straight to
// ST_OUT. The finish waits in ST_OUT while a previous result is still held. The result sits
// in an output register, so the next item is taken while it waits. The store has no reset:
// a sample must only hit voxels that were loaded before.
module sampled_voxel_mean_std_top (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [6:0]  cfg_data,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  func,
    input  logic [16:0] voxel_addr,
    input  logic [7:0]  voxel_value,
    input  logic signed [15:0] pt_x,
    input  logic signed [15:0] pt_y,
    input  logic signed [15:0] pt_z,

    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] mean_out,
    output logic [15:0] std_out,
    output logic [16:0] sample_count,
    output logic        overflow_flag
);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_ADDR = 4'd1;
    localparam logic [3:0] ST_ACC  = 4'd2;
    localparam logic [3:0] ST_MULA = 4'd3;
    localparam logic [3:0] ST_MULB = 4'd4;
    localparam logic [3:0] ST_DIFF = 4'd5;
    localparam logic [3:0] ST_ROOT = 4'd6;
    localparam logic [3:0] ST_DIVS = 4'd7;
    localparam logic [3:0] ST_OUT  = 4'd8;

    localparam int CW  = svms_pkg::COUNT_W;
    localparam int SW  = svms_pkg::SUM_W;
    localparam int QW  = svms_pkg::SUMSQ_W;
    localparam int XYW = svms_pkg::SIZE_XY_W;
    localparam int CRW = svms_pkg::COORD_W;

    // Result of rounding one coordinate and checking it against its size.
    typedef struct packed {
        logic           ok;
        logic [CRW-1:0] val;
    } coord_t;

    // Add one half, truncate toward zero, compare with the limit.
    function automatic coord_t check_coord(input logic [15:0] p, input logic [XYW-1:0] lim);
        coord_t     r;
        logic [16:0] t;
        t = {p[15], p} + 17'd8;
        if (t[16])
        begin
            // Values in (-1, 0) truncate to zero and count as inside.
            r.ok  = (t[16:4] == '1) && (t[3:0] != 4'd0) && (lim != '0);
            r.val = '0;
        end
        else
        begin
            r.ok  = t[15:4] < 12'(lim);
            r.val = t[CRW+3:4];
        end
        return r;
    endfunction

    logic [3:0]      state_reg;
    logic [XYW-1:0]  size_x_reg;
    logic [XYW-1:0]  size_y_reg;
    logic [svms_pkg::SIZE_Z_W-1:0] size_z_reg;

    logic [CW-1:0]   count_acc_reg;
    logic [SW-1:0]   sum_acc_reg;
    logic [QW-1:0]   sumsq_acc_reg;
    logic            dropped_reg;

    logic [CRW-1:0]  x_reg;
    logic [svms_pkg::ZY_W-1:0] zy_reg;

    logic [CW+QW-1:0] prod_a_reg;
    logic [2*SW-1:0]  prod_b_reg;

    logic [31:0]     div_num_reg;
    logic [CW:0]     div_rem_reg;
    logic [31:0]     div_q_reg;
    logic [63:0]     sq_x_reg;
    logic [33:0]     sq_rem_reg;
    logic [31:0]     sq_root_reg;
    logic [4:0]      step_reg;

    logic [15:0]     mean_reg;
    logic [15:0]     sd_reg;

    logic            out_valid_reg;
    logic [15:0]     mean_out_reg;
    logic [15:0]     std_out_reg;
    logic [CW-1:0]   sample_count_reg;
    logic            overflow_flag_reg;

    logic [XYW-1:0]  sx;
    logic [XYW-1:0]  sy;
    logic [XYW-1:0]  sz;
    coord_t          cx;
    coord_t          cy;
    coord_t          cz;
    logic            pt_inside;
    logic            in_accept;
    logic            out_free;
    logic            ram_we;
    logic [svms_pkg::STORE_AW-1:0] rd_addr;
    logic [svms_pkg::VOXEL_W-1:0]  rd_data;

    logic [CW:0]     div_sh;
    logic            div_ge;
    logic [CW:0]     div_rem_step;
    logic [31:0]     div_q_step;
    logic [33:0]     sq_sh;
    logic [33:0]     sq_trial;
    logic            sq_ge;
    logic [31:0]     sq_root_step;
    logic [CW+QW-1:0] diff;

    // Sizes above the volume fall back to the volume.
    assign sx = (size_x_reg > XYW'(svms_pkg::VOL_X)) ? XYW'(svms_pkg::VOL_X) : size_x_reg;
    assign sy = (size_y_reg > XYW'(svms_pkg::VOL_Y)) ? XYW'(svms_pkg::VOL_Y) : size_y_reg;
    assign sz = ({1'b0, size_z_reg} > XYW'(svms_pkg::VOL_Z)) ?
                XYW'(svms_pkg::VOL_Z) : {1'b0, size_z_reg};

    assign cx        = check_coord(pt_x, sx);
    assign cy        = check_coord(pt_y, sy);
    assign cz        = check_coord(pt_z, sz);
    assign pt_inside = cx.ok && cy.ok && cz.ok;

    // Items are taken only between operations.
    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;

    assign ram_we  = in_accept && (func == svms_pkg::FUNC_LOAD);
    // Second half of the address: (z * sy + y) * sx + x.
    assign rd_addr = svms_pkg::STORE_AW'(18'(zy_reg) * 18'(sx) + 18'(x_reg));

    svms_ram #(
        .WIDTH(svms_pkg::VOXEL_W),
        .DEPTH(svms_pkg::STORE_DEPTH)
    ) u_store (
        .clk  (clk),
        .we   (ram_we),
        .waddr(voxel_addr),
        .wdata(voxel_value),
        .raddr(rd_addr),
        .rdata(rd_data)
    );

    // One step of the restoring divider; the divisor is the sample count.
    assign div_sh       = {div_rem_reg[CW-1:0], div_num_reg[31]};
    assign div_ge       = div_sh >= {1'b0, count_acc_reg};
    assign div_rem_step = div_ge ? div_sh - {1'b0, count_acc_reg} : div_sh;
    assign div_q_step   = {div_q_reg[30:0], div_ge};

    // One step of the digit-by-digit square root, two radicand bits a cycle.
    assign sq_sh        = {sq_rem_reg[31:0], sq_x_reg[63:62]};
    assign sq_trial     = {sq_root_reg, 2'b01};
    assign sq_ge        = sq_sh >= sq_trial;
    assign sq_root_step = {sq_root_reg[30:0], sq_ge};

    // n * sumsq - sum^2, held at zero if negative.
    assign diff = (prod_a_reg > (CW+QW)'(prod_b_reg)) ?
                  prod_a_reg - (CW+QW)'(prod_b_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            size_x_reg    <= XYW'(64);
            size_y_reg    <= XYW'(64);
            size_z_reg    <= svms_pkg::SIZE_Z_W'(32);
            count_acc_reg <= '0;
            sum_acc_reg   <= '0;
            sumsq_acc_reg <= '0;
            dropped_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            step_reg      <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    svms_pkg::CFG_SIZE_X: size_x_reg <= cfg_data;
                    svms_pkg::CFG_SIZE_Y: size_y_reg <= cfg_data;
                    svms_pkg::CFG_SIZE_Z: size_z_reg <= cfg_data[svms_pkg::SIZE_Z_W-1:0];
                    default: ;
                endcase
            end

            // A new result replaces the old one in the same cycle the old one is taken.
            if (state_reg == ST_OUT && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_accept && func == svms_pkg::FUNC_SAMPLE && pt_inside)
                    begin
                        if (count_acc_reg >= CW'(svms_pkg::POINT_LIMIT))
                        begin
                            dropped_reg <= 1'b1;
                        end
                        else
                        begin
                            state_reg <= ST_ADDR;
                        end
                    end
                    else if (in_accept && func == svms_pkg::FUNC_FINISH)
                    begin
                        state_reg <= (count_acc_reg == '0) ? ST_OUT : ST_MULA;
                    end
                end
                ST_ADDR: state_reg <= ST_ACC;
                ST_ACC:
                begin
                    count_acc_reg <= count_acc_reg + CW'(1);
                    sum_acc_reg   <= sum_acc_reg + SW'(rd_data);
                    sumsq_acc_reg <= sumsq_acc_reg + QW'(16'(rd_data) * 16'(rd_data));
                    state_reg     <= ST_IDLE;
                end
                ST_MULA: state_reg <= ST_MULB;
                ST_MULB: state_reg <= ST_DIFF;
                ST_DIFF:
                begin
                    step_reg  <= '0;
                    state_reg <= ST_ROOT;
                end
                ST_ROOT:
                begin
                    step_reg <= step_reg + 5'd1;
                    if (step_reg == 5'd31)
                    begin
                        state_reg <= ST_DIVS;
                    end
                end
                ST_DIVS:
                begin
                    step_reg <= step_reg + 5'd1;
                    if (step_reg == 5'd31)
                    begin
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT:
                begin
                    if (out_free)
                    begin
                        count_acc_reg <= '0;
                        sum_acc_reg   <= '0;
                        sumsq_acc_reg <= '0;
                        dropped_reg   <= 1'b0;
                        state_reg     <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // Datapath registers; they need no reset.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                // First half of the address: z * sy + y.
                x_reg    <= cx.val;
                zy_reg   <= svms_pkg::ZY_W'(13'(cz.val) * 13'(sy) + 13'(cy.val));
                mean_reg <= '0;
                sd_reg   <= '0;
            end
            ST_MULA: prod_a_reg <= (CW+QW)'(count_acc_reg) * (CW+QW)'(sumsq_acc_reg);
            ST_MULB: prod_b_reg <= (2*SW)'(sum_acc_reg) * (2*SW)'(sum_acc_reg);
            ST_DIFF:
            begin
                sq_x_reg    <= {diff[47:0], 16'd0};
                sq_rem_reg  <= '0;
                sq_root_reg <= '0;
                div_num_reg <= {sum_acc_reg, 8'd0};
                div_rem_reg <= '0;
                div_q_reg   <= '0;
            end
            ST_ROOT:
            begin
                sq_x_reg    <= {sq_x_reg[61:0], 2'b00};
                sq_rem_reg  <= sq_ge ? sq_sh - sq_trial : sq_sh;
                sq_root_reg <= sq_root_step;
                if (step_reg == 5'd31)
                begin
                    // Mean is done; the divider now scales the root.
                    mean_reg    <= div_q_step[15:0];
                    div_num_reg <= sq_root_step;
                    div_rem_reg <= '0;
                    div_q_reg   <= '0;
                end
                else
                begin
                    div_num_reg <= {div_num_reg[30:0], 1'b0};
                    div_rem_reg <= div_rem_step;
                    div_q_reg   <= div_q_step;
                end
            end
            ST_DIVS:
            begin
                div_num_reg <= {div_num_reg[30:0], 1'b0};
                div_rem_reg <= div_rem_step;
                div_q_reg   <= div_q_step;
                if (step_reg == 5'd31)
                begin
                    sd_reg <= div_q_step[15:0];
                end
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    mean_out_reg      <= mean_reg;
                    std_out_reg       <= sd_reg;
                    sample_count_reg  <= count_acc_reg;
                    overflow_flag_reg <= dropped_reg;
                end
            end
            default: ;
        endcase
    end

    assign out_valid     = out_valid_reg;
    assign mean_out      = mean_out_reg;
    assign std_out       = std_out_reg;
    assign sample_count  = sample_count_reg;
    assign overflow_flag = overflow_flag_reg;

    // The count never passes the point limit.
    a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
        count_acc_reg <= CW'(svms_pkg::POINT_LIMIT))
        else $error("sample count passed the point limit");

    // A result appears only from the report state.
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_OUT)
        else $error("result raised outside the report state");

    // Reporting leaves the accumulators clear.
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OUT && out_free) |=>
        (count_acc_reg == '0 && sum_acc_reg == '0 && sumsq_acc_reg == '0 && !dropped_reg))
        else $error("accumulators not cleared after report");

    // The divider remainder stays below the divisor while it runs.
    a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROOT || state_reg == ST_DIVS) |-> div_rem_reg < {1'b0, count_acc_reg})
        else $error("divider remainder out of range");

    // A store read is always followed by its accumulate.
    a_read_acc: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_ADDR |=> state_reg == ST_ACC)
        else $error("store read not followed by accumulate");

endmodule

FILE: sv/svms_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
module svms_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
